// File: rtl/core/radix64_stream_encoder_macros.svh
// Assertion macros shared by the radix64 stream encoder RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef RADIX64_STREAM_ENCODER_MACROS_SVH
`define RADIX64_STREAM_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge outside reset
`define R64_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("radix64 encoder assertion failed");

// expr must never be true outside reset
`define R64_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("radix64 encoder forbidden condition");

`else

`define R64_ASSERT(lbl, clk, rstn, prop)

`define R64_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// File: rtl/core/r64enc_pkg.sv
// Shared types, constants and the symbol alphabet for the radix64 encoder.
// No dependencies.
package r64enc_pkg;

	localparam int LINE_CHARS = 64;
	// line length kept within 2..127 so one byte never needs more than three words
	localparam int LINE_LIMIT = (LINE_CHARS < 2) ? 2 : ((LINE_CHARS > 127) ? 127 : LINE_CHARS);
	localparam int COL_W      = 7;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [7:0] NEWLINE_CHAR = 8'd10;

	// one symbol job from front to back
	typedef struct packed {
		logic [5:0] grp;
		logic       run_end;
		logic       stream_end;
	} job_t;

	function automatic logic [7:0] sym_char(input logic [5:0] g);
		logic [7:0] c;
		if (g < 6'd26)
			c = 8'd65 + {2'b0, g};
		else if (g < 6'd52)
			c = 8'd97 + {2'b0, g} - 8'd26;
		else if (g < 6'd62)
			c = 8'd48 + {2'b0, g} - 8'd52;
		else if (g == 6'd62)
			c = 8'd95;
		else
			c = 8'd58;
		return c;
	endfunction

endpackage

// File: rtl/core/radix64_stream_encoder.sv
// radix64_stream_encoder: bytes in, 6-bit symbols of a 64-character alphabet out.
// A byte's first character goes through the job queue and then the output register.
// A byte per cycle while the queue has room; a two-symbol byte stalls input until its
// second job is queued. Output: a character per cycle unless stalled; newlines extra.
// Reset (arst_n low, asynchronous) clears bit buffer, queue, line column and output.
// Depends on r64enc_pkg, r64enc_front, r64enc_queue, r64enc_back.
module radix64_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       run_end,
	output logic       stream_end
);
	import r64enc_pkg::*;

	logic push;
	job_t push_job;
	logic q_full;
	logic q_nonempty;
	job_t q_head;
	logic pop;

	r64enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	r64enc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	r64enc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.nonempty   (q_nonempty),
		.head       (q_head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

endmodule

// File: rtl/core/r64enc_front.sv
// Front end: accepts bytes, keeps the bit buffer and splits bits into symbol jobs.
// Depends on r64enc_pkg and the assertion macro header.
`include "radix64_stream_encoder_macros.svh"

module r64enc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	input  logic              q_full,
	output logic              push,
	output r64enc_pkg::job_t  push_job
);
	import r64enc_pkg::*;

	logic [5:0]  buf_q;
	logic [2:0]  cnt_q;
	logic        pend_q;
	job_t        pend_job_q;
	logic        accept;
	logic [11:0] acc;
	logic        second;

	assign in_stall = pend_q | q_full;
	assign accept   = in_valid & ~in_stall;
	assign acc      = {6'b0, buf_q} | ({4'b0, data_byte} << cnt_q);
	// a second symbol follows when six bits remain, or to flush on the last byte
	assign second   = (cnt_q == 3'd4) || final_byte;
	assign push     = accept | (pend_q & ~q_full);

	always_comb begin
		if (accept) begin
			push_job.grp        = acc[5:0];
			push_job.run_end    = ~second;
			push_job.stream_end = 1'b0;
		end else begin
			push_job = pend_job_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= second;
			if (final_byte || cnt_q == 3'd4) begin
				buf_q <= '0;
				cnt_q <= '0;
			end else begin
				buf_q <= acc[11:6];
				cnt_q <= cnt_q + 3'd2;
			end
		end else if (pend_q && !q_full) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_job_q.grp        <= acc[11:6];
			pend_job_q.run_end    <= 1'b1;
			pend_job_q.stream_end <= final_byte;
		end
	end

	`R64_ASSERT(second_queued, clk, arst_n, accept && second |=> pend_q)
	`R64_NEVER(odd_count, clk, arst_n, cnt_q[0] || cnt_q > 3'd4)
	`R64_NEVER(stale_bits, clk, arst_n, cnt_q == 3'd0 && buf_q != 6'd0)

endmodule

// File: rtl/core/r64enc_queue.sv
// Short job queue between the front and back ends.
// Depends on r64enc_pkg and the assertion macro header.
`include "radix64_stream_encoder_macros.svh"

module r64enc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  r64enc_pkg::job_t  push_job,
	output logic              full,
	input  logic              pop,
	output logic              nonempty,
	output r64enc_pkg::job_t  head
);
	import r64enc_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`R64_NEVER(q_overflow, clk, arst_n, push && full)
	`R64_NEVER(q_underflow, clk, arst_n, pop && !nonempty)
	`R64_NEVER(q_count_range, clk, arst_n, cnt_q > QCNT_W'(QDEPTH))

endmodule

// File: rtl/core/r64enc_back.sv
// Back end: maps jobs to characters, inserts newlines, holds the output register.
// Depends on r64enc_pkg and the assertion macro header.
`include "radix64_stream_encoder_macros.svh"

module r64enc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              nonempty,
	input  r64enc_pkg::job_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_char,
	output logic              run_end,
	output logic              stream_end
);
	import r64enc_pkg::*;

	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             run_end_q;
	logic             stream_end_q;
	logic [COL_W-1:0] col_q;
	logic             load;
	logic             line_full;

	assign load      = nonempty & (~out_valid_q | ~out_stall);
	assign line_full = (col_q >= COL_W'(LINE_LIMIT));
	// a newline word leaves the job at the head for the next load
	assign pop       = load & ~line_full;

	assign out_valid  = out_valid_q;
	assign out_char   = char_q;
	assign run_end    = run_end_q;
	assign stream_end = stream_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			col_q       <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (load) begin
				if (line_full)
					col_q <= '0;
				else if (head.stream_end)
					col_q <= '0;
				else
					col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (line_full) begin
				char_q       <= NEWLINE_CHAR;
				run_end_q    <= 1'b0;
				stream_end_q <= 1'b0;
			end else begin
				char_q       <= sym_char(head.grp);
				run_end_q    <= head.run_end;
				stream_end_q <= head.stream_end;
			end
		end
	end

	`R64_NEVER(col_range, clk, arst_n, col_q > COL_W'(LINE_LIMIT))
	`R64_ASSERT(newline_plain, clk, arst_n,
		load && line_full |=> !run_end_q && !stream_end_q)
	`R64_ASSERT(newline_resets_col, clk, arst_n, load && line_full |=> col_q == '0)

endmodule

// File: bench/radix64_char_checker.sv
// Checker for radix64_stream_encoder: watches both channels, predicts the characters
// and compares every accepted output word with the oldest prediction.
// Depends on r64enc_pkg for the line limit and the newline code.
module radix64_char_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_char,
	input  logic       run_end,
	input  logic       stream_end,
	output int         fail_count,
	output int         pending
);
	import r64enc_pkg::*;

	localparam logic [0:63][7:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_:";

	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       stream_end;
	} char_word_t;

	char_word_t expected_chars[$];
	logic [5:0] held_bits;
	logic [2:0] held_count;
	logic [6:0] column;

	task automatic push_symbol(input logic [5:0] grp);
		char_word_t w;
		if (column >= LINE_LIMIT) begin
			w = '{NEWLINE_CHAR, 1'b0, 1'b0};
			expected_chars.push_back(w);
			column = '0;
		end
		w = '{ALPHABET[grp], 1'b0, 1'b0};
		expected_chars.push_back(w);
		column = column + 7'd1;
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic last);
		logic [13:0] acc;
		int          bits;
		char_word_t  w;
		acc = {8'b0, held_bits} | ({6'b0, b} << held_count);
		bits = held_count + 8;
		push_symbol(acc[5:0]);
		acc = acc >> 6;
		bits = bits - 6;
		// six bits left over go out right away
		if (bits >= 6) begin
			push_symbol(acc[5:0]);
			acc = acc >> 6;
			bits = bits - 6;
		end
		// flush only when something is still buffered
		if (last && bits > 0) begin
			push_symbol(acc[5:0]);
			acc = '0;
			bits = 0;
		end
		w = expected_chars.pop_back();
		w.run_end = 1'b1;
		w.stream_end = last;
		expected_chars.push_back(w);
		if (last) begin
			held_bits = '0;
			held_count = '0;
			column = '0;
		end else begin
			held_bits = acc[5:0];
			held_count = bits[2:0];
		end
	endtask

	task automatic compare_char();
		char_word_t w;
		if (expected_chars.size() == 0) begin
			$display("%0t: unexpected word: char %0d run_end %0b stream_end %0b",
				$time, out_char, run_end, stream_end);
			fail_count = fail_count + 1;
		end else begin
			w = expected_chars.pop_front();
			if (out_char !== w.ch) begin
				$display("%0t: out_char expected %0d actual %0d", $time, w.ch, out_char);
				fail_count = fail_count + 1;
			end
			if (run_end !== w.run_end) begin
				$display("%0t: run_end expected %0b actual %0b", $time, w.run_end, run_end);
				fail_count = fail_count + 1;
			end
			if (stream_end !== w.stream_end) begin
				$display("%0t: stream_end expected %0b actual %0b",
					$time, w.stream_end, stream_end);
				fail_count = fail_count + 1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_chars.delete();
			held_bits = '0;
			held_count = '0;
			column = '0;
			fail_count = 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				encode_byte(data_byte, final_byte);
			if (out_valid && !out_stall)
				compare_char();
			pending <= expected_chars.size();
		end
	end

endmodule

// File: bench/testbench.sv
// Top of the radix64_stream_encoder bench: clock, reset, byte streams and output stalls.
// Checking is done by radix64_char_checker; depends on the encoder RTL and r64enc_pkg.
module testbench;

	localparam int CYCLE_LIMIT = 50000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       final_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_char;
	logic       run_end;
	logic       stream_end;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;

	radix64_stream_encoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

	radix64_char_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.run_end    (run_end),
		.stream_end (stream_end),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off when hold_left is loaded
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left = hold_left - 1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// random streams until about n_words bytes went out; first_len > 0 forces a long one first
	task automatic send_streams(input int n_words, input int first_len);
		int sent;
		int len;
		sent = 0;
		while (sent < n_words) begin
			if (sent == 0 && first_len > 0)
				len = first_len;
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(20, 45);
			else
				len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++)
				send_byte($urandom_range(0, 255), i == len - 1);
			sent = sent + len;
		end
	endtask

	// sender stops offering until every predicted word has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		final_byte <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 7;
		recv_idle_pct = 70;
		// one-byte streams: flush of two leftover bits
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// third byte leaves six bits, then nothing to flush
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b1);
		// last byte with two bits buffered: four-bit flush
		send_byte(8'h3C, 1'b0);
		send_byte(8'hC3, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h55, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_streams(40, 50);
		drain();

		send_idle_pct = 70;
		recv_idle_pct = 7;
		send_streams(12, 0);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 60;
		send_streams(14, 0);
		drain();

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/r64enc_pkg.sv
rtl/core/r64enc_front.sv
rtl/core/r64enc_queue.sv
rtl/core/r64enc_back.sv
rtl/core/radix64_stream_encoder.sv
bench/radix64_char_checker.sv
bench/testbench.sv
